// ----- design/pcpd_pkg.sv -----
package pcpd_pkg;

   localparam int MaxVertices = 64;
   localparam int IdxBits = $clog2(MaxVertices);
   localparam int CountBits = 7;
   localparam int CoordBits = 16;
   localparam int DistBits = 25;
   localparam int DistTopBit = DistBits - 1;
   localparam int DistFracBits = 8;
   localparam logic [DistBits-1:0] DistMax = 25'd25165823;

   localparam logic KindVertex = 1'b0;
   localparam logic KindQuery = 1'b1;

   localparam logic [1:0] PathInside = 2'd0;
   localparam logic [1:0] PathEdge = 2'd1;
   localparam logic [1:0] PathVertex = 2'd2;

   typedef struct packed {
      logic                        kind;
      logic [IdxBits-1:0]          vertex_index;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic                 inside_res;
      logic [1:0]           path_taken;
      logic [DistBits-1:0]  distance;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IN_RD,
      ST_IN_MUL,
      ST_IN_CHK,
      ST_ED_RD,
      ST_ED_MUL,
      ST_ED_CHK,
      ST_VX_RD,
      ST_VX_MUL,
      ST_VX_CHK,
      ST_ROOT_SQ,
      ST_ROOT_MUL,
      ST_ROOT_CHK,
      ST_OUT
   } state_type;

   // shared multiplier operation
   typedef struct packed {
      logic signed [33:0] a;
      logic signed [33:0] b;
   } mul_op_type;

endpackage

// ----- design/pcpd_stream_if.sv -----
interface pcpd_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/point_to_convex_polygon_distance.sv -----
// channel  | dir | payload
// req      | in  | kind, vertex_index, coord_x, coord_y
// rsp      | out | inside_res, path_taken, distance
// csr      | in  | vertex_count (write only)
// A vertex request is written to the vertex table. A query runs the inside test
// over each edge, then the edge search over each edge (an edge may be dropped early),
// then a search over each vertex if no edge qualifies, then setup and a 25-step
// root; all through one shared multiplier and the vertex table.
// Reset is synchronous; req.ready stays low until the response is taken.
module point_to_convex_polygon_distance (
   input  logic                         clock,
   input  logic                         reset,
   pcpd_stream_if.sink                  req,
   pcpd_stream_if.source                rsp,
   input  logic                         csr_we,
   input  logic [pcpd_pkg::CountBits-1:0] csr_wdata
);
   localparam int IB = pcpd_pkg::IdxBits;
   localparam int CB = pcpd_pkg::CountBits;
   localparam int DistBitsL = pcpd_pkg::DistBits;

   pcpd_pkg::state_type state_ff, state_in;
   logic [CB-1:0] count_ff;
   logic [IB:0] n_w;
   pcpd_pkg::req_type rq;

   logic [IB:0]  i_ff, i_in;
   logic [2:0]   sub_ff, sub_in;
   logic signed [15:0] px_ff, py_ff, ax_ff, ay_ff, ax_in, ay_in;
   logic signed [67:0] acc_ff, acc_in;
   logic signed [67:0] len2_ff, len2_in;
   logic [67:0] num_ff, num_in;      // root numerator
   logic [67:0] den_ff, den_in;
   logic [67:0] best_ff, best_in;
   logic [DistBitsL-1:0] d_ff, d_in;
   logic [4:0] bit_ff, bit_in;
   logic [1:0] path_ff, path_in;
   logic       inside_ff, inside_in;

   logic [IB-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic signed [15:0] bx, by;
   pcpd_pkg::mul_op_type op;
   logic signed [67:0] prod;

   assign rq = pcpd_pkg::req_type'(req.payload);
   assign n_w = (count_ff > CB'(pcpd_pkg::MaxVertices)) ?
                (IB+1)'(pcpd_pkg::MaxVertices) : count_ff[IB:0];
   assign bx = rd_data[31:16];
   assign by = rd_data[15:0];

   pcpd_vtab u_vtab (
      .clock(clock),
      .wr_en(req.valid && req.ready && rq.kind == pcpd_pkg::KindVertex),
      .wr_addr(rq.vertex_index),
      .wr_data({rq.coord_x, rq.coord_y}),
      .rd_addr(rd_addr),
      .rd_data_ff(rd_data)
   );

   pcpd_mul u_mul (.clock(clock), .op(op), .prod_ff(prod));

   assign req.ready = (state_ff == pcpd_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == pcpd_pkg::ST_OUT);
   assign rsp.payload = {inside_ff, path_ff, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcpd_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
      i_ff <= i_in; sub_ff <= sub_in; ax_ff <= ax_in; ay_ff <= ay_in;
      acc_ff <= acc_in; len2_ff <= len2_in; num_ff <= num_in; den_ff <= den_in;
      best_ff <= best_in; d_ff <= d_in; bit_ff <= bit_in;
      path_ff <= path_in; inside_ff <= inside_in;
      if (req.valid && req.ready) begin
         px_ff <= rq.coord_x;
         py_ff <= rq.coord_y;
      end
   end

   // next slot, cyclic
   function automatic logic [IB:0] nxt(input logic [IB:0] i, input logic [IB:0] n);
      nxt = (i + 1'b1 == n) ? '0 : i + 1'b1;
   endfunction

   logic [IB:0] j_w;
   assign j_w = nxt(i_ff, n_w);

   logic signed [67:0] ex, ey, dxp, dyp;
   logic [DistBitsL-1:0] cand;
   logic [67:0] mag;
   logic [85:0] root_lhs, root_rhs;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; sub_in = sub_ff; ax_in = ax_ff; ay_in = ay_ff;
      acc_in = acc_ff; len2_in = len2_ff; num_in = num_ff; den_in = den_ff;
      best_in = best_ff; d_in = d_ff; bit_in = bit_ff;
      path_in = path_ff; inside_in = inside_ff;
      rd_addr = i_ff[IB-1:0];
      op.a = '0; op.b = '0;
      ex = 68'(bx) - 68'(ax_ff);
      ey = 68'(by) - 68'(ay_ff);
      dxp = 68'(px_ff) - 68'(ax_ff);
      dyp = 68'(py_ff) - 68'(ay_ff);
      cand = d_ff | (DistBitsL'(1) << bit_ff);
      mag = acc_ff[67] ? 68'(-acc_ff) : 68'(acc_ff);
      // cand^2 * den = hi*den << 33 + lo*den, lo part parked in best
      root_lhs = (86'(prod[50:0]) << 33) + 86'(best_ff);
      root_rhs = 86'(num_ff) << (2 * pcpd_pkg::DistFracBits);
      case (state_ff)
         pcpd_pkg::ST_IDLE: begin
            i_in = '0;
            rd_addr = '0;
            if (req.valid && rq.kind == pcpd_pkg::KindQuery) begin
               if (n_w == '0) begin
                  inside_in = 1'b1; path_in = pcpd_pkg::PathInside; d_in = '0;
                  state_in = pcpd_pkg::ST_OUT;
               end else begin
                  state_in = pcpd_pkg::ST_IN_RD;
               end
            end
         end
         // read a = vertex i, then b = vertex j
         pcpd_pkg::ST_IN_RD, pcpd_pkg::ST_ED_RD: begin
            ax_in = bx; ay_in = by;
            rd_addr = j_w[IB-1:0];
            sub_in = '0;
            state_in = (state_ff == pcpd_pkg::ST_IN_RD) ?
                       pcpd_pkg::ST_IN_MUL : pcpd_pkg::ST_ED_MUL;
         end
         pcpd_pkg::ST_IN_MUL: begin
            // z = (ax-bx)*(by-py) - (ay-by)*(bx-px)
            rd_addr = j_w[IB-1:0];
            if (sub_ff == 3'd0) begin
               op.a = 34'(ax_ff) - 34'(bx); op.b = 34'(by) - 34'(py_ff);
               sub_in = 3'd1;
            end else begin
               op.a = 34'(ay_ff) - 34'(by); op.b = 34'(bx) - 34'(px_ff);
               acc_in = prod;
               state_in = pcpd_pkg::ST_IN_CHK;
            end
         end
         pcpd_pkg::ST_IN_CHK: begin
            rd_addr = j_w[IB-1:0];
            if (acc_ff - prod <= 0) begin
               i_in = '0; rd_addr = '0;
               state_in = pcpd_pkg::ST_ED_RD;
            end else if (i_ff + 1'b1 == n_w) begin
               inside_in = 1'b1; path_in = pcpd_pkg::PathInside; d_in = '0;
               state_in = pcpd_pkg::ST_OUT;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = pcpd_pkg::ST_IN_RD;
            end
         end
         pcpd_pkg::ST_ED_MUL: begin
            rd_addr = j_w[IB-1:0];
            sub_in = sub_ff + 1'b1;
            case (sub_ff)
               3'd0: begin op.a = 34'(ex); op.b = 34'(ex); end
               3'd1: begin op.a = 34'(ey); op.b = 34'(ey); acc_in = prod; end
               3'd2: begin
                  op.a = 34'(ex); op.b = 34'(dyp); len2_in = acc_ff + prod;
               end
               3'd3: begin op.a = 34'(ey); op.b = 34'(dxp); acc_in = prod; end
               3'd4: begin
                  op.a = 34'(dxp); op.b = 34'(ex);
                  // acc = ex*dy - ey*dx (cross)
                  acc_in = acc_ff - prod;
                  if (len2_ff == 0 || acc_ff > prod) begin
                     state_in = pcpd_pkg::ST_ED_CHK; sub_in = 3'd7;
                  end
               end
               3'd5: begin
                  op.a = 34'(dyp); op.b = 34'(ey); num_in = 68'(prod);
               end
               default: begin
                  num_in = 68'(num_ff) + 68'(prod);
                  state_in = pcpd_pkg::ST_ED_CHK; sub_in = '0;
               end
            endcase
         end
         pcpd_pkg::ST_ED_CHK: begin
            // sub 7 here means skipped; else num holds t
            if (sub_ff != 3'd7 && !num_ff[67] &&
                $signed(num_ff) <= len2_ff) begin
               num_in = mag; den_in = 68'(len2_ff);
               path_in = pcpd_pkg::PathEdge; inside_in = 1'b0;
               d_in = '0; bit_in = 5'(pcpd_pkg::DistTopBit);
               state_in = pcpd_pkg::ST_ROOT_SQ; sub_in = '0;
            end else if (i_ff + 1'b1 == n_w) begin
               i_in = '0; rd_addr = '0; best_in = '1;
               state_in = pcpd_pkg::ST_VX_RD;
            end else begin
               i_in = i_ff + 1'b1; rd_addr = i_ff[IB-1:0] + 1'b1;
               state_in = pcpd_pkg::ST_ED_RD;
            end
         end
         pcpd_pkg::ST_VX_RD: begin
            ax_in = bx; ay_in = by; sub_in = '0;
            state_in = pcpd_pkg::ST_VX_MUL;
         end
         pcpd_pkg::ST_VX_MUL: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd0) begin
               op.a = 34'(dxp); op.b = 34'(dxp);
            end else if (sub_ff == 3'd1) begin
               op.a = 34'(dyp); op.b = 34'(dyp); acc_in = prod;
            end else begin
               acc_in = acc_ff + prod;
               state_in = pcpd_pkg::ST_VX_CHK;
            end
         end
         pcpd_pkg::ST_VX_CHK: begin
            rd_addr = i_ff[IB-1:0] + 1'b1;
            if (68'(acc_ff) < best_in) best_in = 68'(acc_ff);
            if (i_ff + 1'b1 == n_w) begin
               num_in = best_in; den_in = 68'd1;
               path_in = pcpd_pkg::PathVertex; inside_in = 1'b0;
               d_in = '0; bit_in = 5'(pcpd_pkg::DistTopBit);
               state_in = pcpd_pkg::ST_ROOT_SQ; sub_in = '0;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = pcpd_pkg::ST_VX_RD;
            end
         end
         // root: largest d with d*d*den <= num << 2F; on the edge path num is mag, squared first
         pcpd_pkg::ST_ROOT_SQ: begin
            sub_in = sub_ff + 1'b1;
            if (path_ff == pcpd_pkg::PathEdge) begin
               if (sub_ff == 3'd0) begin
                  op.a = 34'(num_ff); op.b = 34'(num_ff);
               end else begin
                  num_in = 68'(prod);
                  state_in = pcpd_pkg::ST_ROOT_MUL; sub_in = '0;
               end
            end else begin
               state_in = pcpd_pkg::ST_ROOT_MUL; sub_in = '0;
            end
         end
         pcpd_pkg::ST_ROOT_MUL: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd0) begin
               op.a = 34'(cand); op.b = 34'(cand);
            end else if (sub_ff == 3'd1) begin
               // cand^2 split at bit 33 to fit the multiplier
               acc_in = prod;
               op.a = 34'(prod[32:0]); op.b = 34'(den_ff);
            end else begin
               best_in = 68'(prod);
               op.a = 34'(acc_ff[49:33]); op.b = 34'(den_ff);
               state_in = pcpd_pkg::ST_ROOT_CHK;
            end
         end
         pcpd_pkg::ST_ROOT_CHK: begin
            if (cand <= pcpd_pkg::DistMax && root_lhs <= root_rhs)
               d_in = cand;
            sub_in = '0;
            if (bit_ff == '0) state_in = pcpd_pkg::ST_OUT;
            else begin
               bit_in = bit_ff - 1'b1;
               state_in = pcpd_pkg::ST_ROOT_MUL;
            end
         end
         pcpd_pkg::ST_OUT: begin
            if (rsp.ready) state_in = pcpd_pkg::ST_IDLE;
         end
         default: state_in = pcpd_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- design/pcpd_mul.sv -----
// shared signed multiplier, registered product
module pcpd_mul (
   input  logic                      clock,
   input  pcpd_pkg::mul_op_type      op,
   output logic signed [67:0]        prod_ff
);
   logic signed [67:0] prod_in;
   assign prod_in = 68'(op.a) * 68'(op.b);
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ----- design/pcpd_vtab.sv -----
// vertex table: one write port, one registered read port
module pcpd_vtab (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [pcpd_pkg::IdxBits-1:0]       wr_addr,
   input  logic [31:0]                        wr_data,
   input  logic [pcpd_pkg::IdxBits-1:0]       rd_addr,
   output logic [31:0]                        rd_data_ff
);
   logic [31:0] mem [pcpd_pkg::MaxVertices];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
